// ===== hdl/ttc_pkg.sv =====
package ttc_pkg;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CASE_DELTA = 8'd32;

	// result queue geometry
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_end;
	} out_t;

	// up to two results written to the queue in one cycle; res1 follows res0
	typedef struct packed {
		logic push0;
		logic push1;
		out_t res0;
		out_t res1;
	} push_t;

endpackage

// ===== hdl/ttc_result_queue.sv =====
module ttc_result_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  ttc_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output ttc_pkg::out_t  out_data
);

	ttc_pkg::out_t                mem_q [ttc_pkg::RQ_DEPTH];
	logic [ttc_pkg::RQ_AW-1:0]    wr_ptr_q;
	logic [ttc_pkg::RQ_AW-1:0]    rd_ptr_q;
	logic [ttc_pkg::RQ_CW-1:0]    count_q;
	logic [ttc_pkg::RQ_AW-1:0]    wr_ptr_nx;
	logic                         pop;
	logic [ttc_pkg::RQ_CW-1:0]    n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	// keep space for the worst case of two results from the next item
	assign room      = (count_q <= ttc_pkg::RQ_CW'(ttc_pkg::RQ_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + ttc_pkg::RQ_AW'(1);
	assign n_push    = ttc_pkg::RQ_CW'(push.push0) + ttc_pkg::RQ_CW'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_nx] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ttc_pkg::RQ_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ttc_pkg::RQ_AW'(1);
			end
			count_q <= count_q + n_push - ttc_pkg::RQ_CW'(pop);
		end
	end

endmodule

// ===== hdl/text_normalize_title_case.sv =====
// Streaming title-case normalizer. Feed a string one byte per item with
// in_last on its final byte; letters, digits and single inner spaces come
// out, each word capitalized and the rest lower case, and the final result
// of every string carries out_end (a bare end marker with out_valid low if
// the last byte was not a letter or digit). The block takes one item per
// clock while the result queue has room: each item is classified from its
// input register and its zero, one or two results land in a four-entry result
// queue. Input stalls only while that queue holds more than two results, so
// with the output always ready an item is taken every cycle, and a letter that
// follows a held-back space yields two results, the space and then the letter.
module text_normalize_title_case (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ttc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ttc_pkg::out_t out_data
);

	ttc_pkg::in_t   item_s1;
	logic           valid_s1;
	logic           word_seen_q;
	logic           space_pending_q;
	logic           room;
	logic           consume;
	logic           is_upper;
	logic           is_lower;
	logic           is_digit;
	logic           kept;
	logic           word_start;
	logic [7:0]     ch;
	ttc_pkg::out_t  char_res;
	ttc_pkg::out_t  space_res;
	ttc_pkg::out_t  end_res;
	ttc_pkg::push_t push;

	assign consume  = valid_s1 && room;
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign is_upper   = (item_s1.in_byte >= ttc_pkg::CH_UPPER_A)
		&& (item_s1.in_byte <= ttc_pkg::CH_UPPER_Z);
	assign is_lower   = (item_s1.in_byte >= ttc_pkg::CH_LOWER_A)
		&& (item_s1.in_byte <= ttc_pkg::CH_LOWER_Z);
	assign is_digit   = (item_s1.in_byte >= ttc_pkg::CH_DIGIT_0)
		&& (item_s1.in_byte <= ttc_pkg::CH_DIGIT_9);
	assign kept       = is_upper || is_lower || is_digit;
	assign word_start = !word_seen_q || space_pending_q;

	always_comb begin
		ch = item_s1.in_byte;
		if (is_upper && !word_start) begin
			ch = item_s1.in_byte + ttc_pkg::CASE_DELTA;
		end else if (is_lower && word_start) begin
			ch = item_s1.in_byte - ttc_pkg::CASE_DELTA;
		end
	end

	assign char_res  = '{out_byte: ch, out_valid: 1'b1, out_end: item_s1.in_last};
	assign space_res = '{out_byte: ttc_pkg::CH_SPACE, out_valid: 1'b1, out_end: 1'b0};
	assign end_res   = '{out_byte: 8'd0, out_valid: 1'b0, out_end: 1'b1};

	always_comb begin
		push = '{push0: 1'b0, push1: 1'b0, res0: char_res, res1: char_res};
		if (consume) begin
			if (kept) begin
				push.push0 = 1'b1;
				// emit the held-back space ahead of the character
				if (space_pending_q) begin
					push.res0  = space_res;
					push.push1 = 1'b1;
				end
			end else if (item_s1.in_last) begin
				push.push0 = 1'b1;
				push.res0  = end_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_seen_q     <= 1'b0;
			space_pending_q <= 1'b0;
		end else if (consume) begin
			if (item_s1.in_last) begin
				word_seen_q     <= 1'b0;
				space_pending_q <= 1'b0;
			end else if (kept) begin
				word_seen_q     <= 1'b1;
				space_pending_q <= 1'b0;
			end else if (item_s1.in_byte == ttc_pkg::CH_SPACE && word_seen_q) begin
				space_pending_q <= 1'b1;
			end
		end
	end

	ttc_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_space_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		space_pending_q |-> word_seen_q)
		else $error("space pending outside a word");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0 && consume && push.res0.out_byte == ttc_pkg::CH_SPACE)
		else $error("second result pushed without a leading space");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> room)
		else $error("result pushed into a full queue");

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.in_last |=> !word_seen_q && !space_pending_q)
		else $error("word state survives a string end");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		ttc_pkg::in_t  item;
		int            fixed_n;	// -1: take the results from the predictor
		ttc_pkg::out_t fix0;
		ttc_pkg::out_t fix1;
	} stim_row_t;

	localparam ttc_pkg::out_t NO_RESULT = '0;
	localparam ttc_pkg::out_t END_MARK  =
		'{out_byte: 8'h00, out_valid: 1'b0, out_end: 1'b1};
	localparam int   RAND_ITEMS = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ttc_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ttc_pkg::out_t out_data;

	// predictor state
	bit word_started;
	bit space_held;

	ttc_pkg::out_t pending_chars[$];
	stim_row_t dir_rows[$];
	bit   no_idle;
	int   items_sent;
	int   results_seen;
	int   strings_done;
	int   mismatches;

	text_normalize_title_case dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ttc_pkg::out_t char_res(logic [7:0] c, logic e);
		return '{out_byte: c, out_valid: 1'b1, out_end: e};
	endfunction

	function automatic bit take_gap();
		return !no_idle && ($urandom_range(0, 99) < 16);
	endfunction

	// Advance the normalizer state by one byte and return its results.
	function automatic int title_case_step(ttc_pkg::in_t item, output ttc_pkg::out_t res[2]);
		logic [7:0] b;
		logic [7:0] ch;
		bit upper, lower, digit, word_start;
		int n;
		b = item.in_byte;
		upper = (b >= ttc_pkg::CH_UPPER_A) && (b <= ttc_pkg::CH_UPPER_Z);
		lower = (b >= ttc_pkg::CH_LOWER_A) && (b <= ttc_pkg::CH_LOWER_Z);
		digit = (b >= ttc_pkg::CH_DIGIT_0) && (b <= ttc_pkg::CH_DIGIT_9);
		n = 0;
		res[0] = NO_RESULT;
		res[1] = NO_RESULT;
		if (upper || lower || digit) begin
			word_start = !word_started || space_held;
			ch = upper ? b + ttc_pkg::CASE_DELTA : b;
			if (space_held) begin
				res[n] = char_res(ttc_pkg::CH_SPACE, 1'b0);
				n++;
			end
			if (word_start && ch >= ttc_pkg::CH_LOWER_A && ch <= ttc_pkg::CH_LOWER_Z)
				ch = ch - ttc_pkg::CASE_DELTA;
			res[n] = char_res(ch, item.in_last);
			n++;
			word_started = 1'b1;
			space_held = 1'b0;
		end else begin
			if (b == ttc_pkg::CH_SPACE && word_started)
				space_held = 1'b1;
			if (item.in_last) begin
				res[n] = END_MARK;
				n++;
			end
		end
		if (item.in_last) begin
			word_started = 1'b0;
			space_held = 1'b0;
		end
		return n;
	endfunction

	task automatic send_char(ttc_pkg::in_t item, int fixed_n = -1,
			ttc_pkg::out_t f0 = '0, ttc_pkg::out_t f1 = '0);
		ttc_pkg::out_t res[2];
		int n;
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n = title_case_step(item, res);
		if (fixed_n >= 0) begin
			n = fixed_n;
			res[0] = f0;
			res[1] = f1;
		end
		for (int i = 0; i < n; i++)
			pending_chars.push_back(res[i]);
		items_sent++;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 8'($urandom_range(ttc_pkg::CH_LOWER_A, ttc_pkg::CH_LOWER_Z));
		if (r < 55)
			return 8'($urandom_range(ttc_pkg::CH_UPPER_A, ttc_pkg::CH_UPPER_Z));
		if (r < 67)
			return 8'($urandom_range(ttc_pkg::CH_DIGIT_0, ttc_pkg::CH_DIGIT_9));
		if (r < 85)
			return ttc_pkg::CH_SPACE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic check_result(ttc_pkg::out_t got);
		ttc_pkg::out_t want;
		results_seen++;
		if (got.out_end)
			strings_done++;
		if (pending_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: byte %h valid %b end %b",
					got.out_byte, got.out_valid, got.out_end);
		end else begin
			want = pending_chars.pop_front();
			if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
					got.out_end !== want.out_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at %0t: want byte %h valid %b end %b, ",
						"got byte %h valid %b end %b"},
						$realtime, want.out_byte, want.out_valid, want.out_end,
						got.out_byte, got.out_valid, got.out_end);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result(out_data);
		out_ready <= !take_gap();
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d results still expected", pending_chars.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		ttc_pkg::in_t item;
		int len;
		int burst;

		dir_rows.push_back('{'{8'h00, 1'b1}, 1, END_MARK, NO_RESULT});
		dir_rows.push_back('{'{ttc_pkg::CH_SPACE, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{ttc_pkg::CH_SPACE, 1'b1}, 1, END_MARK, NO_RESULT});
		dir_rows.push_back('{'{8'h61, 1'b0}, 1, char_res(8'h41, 1'b0), NO_RESULT});
		dir_rows.push_back('{'{8'h5a, 1'b0}, 1, char_res(8'h7a, 1'b0), NO_RESULT});
		dir_rows.push_back('{'{8'hff, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h80, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{ttc_pkg::CH_SPACE, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{ttc_pkg::CH_SPACE, 1'b0}, 0, NO_RESULT, NO_RESULT});
		// word opening with a digit: following letters stay lower case
		dir_rows.push_back('{'{8'h39, 1'b0}, -1, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h51, 1'b0}, -1, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h30, 1'b0}, -1, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h7f, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h7a, 1'b0}, -1, NO_RESULT, NO_RESULT});
		// trailing space: held space is dropped, bare end marker only
		dir_rows.push_back('{'{ttc_pkg::CH_SPACE, 1'b1}, 1, END_MARK, NO_RESULT});
		dir_rows.push_back('{'{8'h41, 1'b1}, 1, char_res(8'h41, 1'b1), NO_RESULT});
		dir_rows.push_back('{'{8'h40, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h5b, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h6d, 1'b0}, -1, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h60, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{ttc_pkg::CH_SPACE, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h7b, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h2f, 1'b0}, 0, NO_RESULT, NO_RESULT});
		dir_rows.push_back('{'{8'h3a, 1'b0}, 0, NO_RESULT, NO_RESULT});
		// last byte is a letter after a held space: space then letter with end
		dir_rows.push_back('{'{8'h78, 1'b1}, -1, NO_RESULT, NO_RESULT});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_char(dir_rows[i].item, dir_rows[i].fixed_n, dir_rows[i].fix0,
				dir_rows[i].fix1);

		while (items_sent < RAND_ITEMS + dir_rows.size()) begin
			no_idle = (items_sent >= 700) && (items_sent < 1000);
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary bytes, arbitrary end flags
				burst = $urandom_range(1, 4);
				repeat (burst) begin
					item.in_byte = 8'($urandom_range(0, 255));
					item.in_last = ($urandom_range(0, 3) == 0);
					send_char(item);
				end
			end else begin
				len = $urandom_range(0, 14);
				repeat (len) begin
					item.in_byte = pick_byte();
					item.in_last = 1'b0;
					send_char(item);
				end
				item.in_byte = pick_byte();
				item.in_last = 1'b1;
				send_char(item);
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d bytes (directed edge cases, random strings and noise)",
			items_sent);
		$display("checked %0d results over %0d strings, %0d mismatches",
			results_seen, strings_done, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
